// ===== src/cdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdc_pkg: shared types and constants of the cup dispense controller
// Holds register indexes, reset values, event codes and the config and
// result bundles passed between the controller modules.
// ----------------------------------------------------------------------------
package cdc_pkg;

	// register file geometry
	localparam int NumRegs   = 8;
	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;

	// register indexes
	localparam logic [2:0] REG_SMALL_PRICE  = 3'd0;
	localparam logic [2:0] REG_LARGE_PRICE  = 3'd1;
	localparam logic [2:0] REG_SMALL_VOLUME = 3'd2;
	localparam logic [2:0] REG_LARGE_VOLUME = 3'd3;
	localparam logic [2:0] REG_CUP_MIN      = 3'd4;
	localparam logic [2:0] REG_CUP_MAX      = 3'd5;
	localparam logic [2:0] REG_TIMEOUT      = 3'd6;
	localparam logic [2:0] REG_START_DELAY  = 3'd7;

	// register reset values
	localparam logic [15:0] RstSmallPrice  = 16'd200;
	localparam logic [15:0] RstLargePrice  = 16'd300;
	localparam logic [9:0]  RstSmallVolume = 10'd100;
	localparam logic [9:0]  RstLargeVolume = 10'd180;
	localparam logic [14:0] RstCupMin      = 15'd48;
	localparam logic [14:0] RstCupMax      = 15'd320;
	localparam logic [23:0] RstTimeout     = 24'd90000;
	localparam logic [15:0] RstStartDelay  = 16'd2000;

	// shortest fill time before a lifted cup counts as an abort
	localparam logic [39:0] MinFillMs = 40'd1000;

	// phase codes as seen on the phase output
	localparam logic [1:0] PHASE_AWAIT_COIN = 2'd0;
	localparam logic [1:0] PHASE_DISPENSING = 2'd1;
	localparam logic [1:0] PHASE_AWAIT_CUP  = 2'd2;

	// controller state, one-hot
	typedef enum logic [2:0] {
		ST_AWAIT_COIN = 3'b001,
		ST_DISPENSING = 3'b010,
		ST_AWAIT_CUP  = 3'b100
	} state_t;

	// event codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STARTED = 3'd1,
		EV_FILLED  = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_EARLY   = 3'd4,
		EV_TAKEN   = 3'd5
	} event_t;

	// configuration bundle
	typedef struct packed {
		logic [15:0] small_price;
		logic [15:0] large_price;
		logic [9:0]  small_volume;
		logic [9:0]  large_volume;
		logic [14:0] cup_min;
		logic [14:0] cup_max;
		logic [23:0] timeout;
		logic [15:0] start_delay;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic        pump_on;
		logic        clear_credit;
		logic        tare_scale;
		logic [1:0]  phase;
		event_t      event_res;
	} res_t;

endpackage

// ===== src/cdc_regs.sv =====
// ----------------------------------------------------------------------------
// cdc_regs: configuration register file
// APB-style register bank holding prices, volumes, cup window and timing
// limits; zero wait states.
// ----------------------------------------------------------------------------
module cdc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdc_pkg::AddrWidth-1:0] paddr,
	input  logic [cdc_pkg::DataWidth-1:0] pwdata,
	output logic [cdc_pkg::DataWidth-1:0] prdata,
	output logic                          pready,
	output cdc_pkg::cfg_t                 cfg
);
	import cdc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.small_price  <= RstSmallPrice;
			cfg_q.large_price  <= RstLargePrice;
			cfg_q.small_volume <= RstSmallVolume;
			cfg_q.large_volume <= RstLargeVolume;
			cfg_q.cup_min      <= RstCupMin;
			cfg_q.cup_max      <= RstCupMax;
			cfg_q.timeout      <= RstTimeout;
			cfg_q.start_delay  <= RstStartDelay;
		end else if (wr_en) begin
			case (idx)
				REG_SMALL_PRICE:  cfg_q.small_price  <= pwdata[15:0];
				REG_LARGE_PRICE:  cfg_q.large_price  <= pwdata[15:0];
				REG_SMALL_VOLUME: cfg_q.small_volume <= pwdata[9:0];
				REG_LARGE_VOLUME: cfg_q.large_volume <= pwdata[9:0];
				REG_CUP_MIN:      cfg_q.cup_min      <= pwdata[14:0];
				REG_CUP_MAX:      cfg_q.cup_max      <= pwdata[14:0];
				REG_TIMEOUT:      cfg_q.timeout      <= pwdata[23:0];
				REG_START_DELAY:  cfg_q.start_delay  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SMALL_PRICE:  prdata = {16'd0, cfg_q.small_price};
			REG_LARGE_PRICE:  prdata = {16'd0, cfg_q.large_price};
			REG_SMALL_VOLUME: prdata = {22'd0, cfg_q.small_volume};
			REG_LARGE_VOLUME: prdata = {22'd0, cfg_q.large_volume};
			REG_CUP_MIN:      prdata = {17'd0, cfg_q.cup_min};
			REG_CUP_MAX:      prdata = {17'd0, cfg_q.cup_max};
			REG_TIMEOUT:      prdata = {8'd0, cfg_q.timeout};
			REG_START_DELAY:  prdata = {16'd0, cfg_q.start_delay};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== src/cdc_step.sv =====
// ----------------------------------------------------------------------------
// cdc_step: dispense state machine
// Holds the controller state and computes one tick's result from the
// registered tick fields; state advances when the tick moves on.
// ----------------------------------------------------------------------------
module cdc_step #(
	parameter logic [39:0] MinFillTimeMs = cdc_pkg::MinFillMs
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic signed [15:0]  weight,
	input  logic [15:0]         credit_cents,
	input  logic [39:0]         now_ms,
	input  cdc_pkg::cfg_t       cfg,
	output cdc_pkg::res_t       res
);
	import cdc_pkg::*;

	state_t              state_q, state_d;
	logic                cup_seen_q, cup_seen_d;
	logic [39:0]         cup_since_q, cup_since_d;
	logic [39:0]         pump_start_q, pump_start_d;
	logic signed [15:0]  start_weight_q, start_weight_d;
	logic [9:0]          target_q, target_d;

	logic signed [16:0]  w_ext;
	logic                below;
	logic                placed;
	logic signed [17:0]  diff;
	logic [16:0]         diff_abs;
	logic [12:0]         vol_mag;
	logic                filled;
	logic [39:0]         pump_el;
	logic                timed_out;
	logic                min_fill_done;
	logic [39:0]         cup_since_eff;
	logic [39:0]         rest_el;
	logic                rested;
	logic                clr;
	event_t              ev;

	// cup window tests, signed weight against unsigned limits
	assign w_ext  = {weight[15], weight};
	assign below  = w_ext < $signed({2'b00, cfg.cup_min});
	assign placed = !below && (w_ext <= $signed({2'b00, cfg.cup_max}));

	// dispensed volume, truncated toward zero
	assign diff     = {{2{weight[15]}}, weight} - {{2{start_weight_q[15]}}, start_weight_q};
	assign diff_abs = diff[17] ? 17'(-diff) : diff[16:0];
	assign vol_mag  = diff_abs[16:4];
	assign filled   = diff[17] ? ((target_q == 10'd0) && (vol_mag == 13'd0))
	                           : (vol_mag >= {3'd0, target_q});

	// dispensing timers, modulo 2^40
	assign pump_el       = now_ms - pump_start_q;
	assign timed_out     = pump_el > {16'd0, cfg.timeout};
	assign min_fill_done = pump_el >= MinFillTimeMs;

	// cup rest timer, arrival time taken from this tick when newly seen
	assign cup_since_eff = (placed && !cup_seen_q) ? now_ms : cup_since_q;
	assign rest_el       = now_ms - cup_since_eff;
	assign rested        = rest_el >= {24'd0, cfg.start_delay};

	// next state
	always_comb begin
		state_d        = state_q;
		cup_seen_d     = cup_seen_q;
		cup_since_d    = cup_since_q;
		pump_start_d   = pump_start_q;
		start_weight_d = start_weight_q;
		target_d       = target_q;
		clr            = 1'b0;
		ev             = EV_NONE;
		case (state_q)
			ST_DISPENSING: begin
				if (filled || timed_out) begin
					state_d = ST_AWAIT_CUP;
					ev      = timed_out ? EV_TIMEOUT : EV_FILLED;
				end else if (below && min_fill_done) begin
					cup_seen_d = 1'b0;
					state_d    = ST_AWAIT_COIN;
					ev         = EV_EARLY;
				end
			end
			ST_AWAIT_CUP: begin
				if (below) begin
					clr        = 1'b1;
					cup_seen_d = 1'b0;
					state_d    = ST_AWAIT_COIN;
					ev         = EV_TAKEN;
				end
			end
			default: begin
				state_d     = ST_AWAIT_COIN;
				cup_seen_d  = placed;
				cup_since_d = cup_since_eff;
				if (placed && (credit_cents >= cfg.small_price) && rested) begin
					target_d       = (credit_cents >= cfg.large_price) ? cfg.large_volume
					                                                   : cfg.small_volume;
					start_weight_d = weight;
					pump_start_d   = now_ms;
					state_d        = ST_DISPENSING;
					ev             = EV_STARTED;
				end
			end
		endcase
	end

	// result of this tick
	always_comb begin
		res.pump_on      = (state_d == ST_DISPENSING);
		res.clear_credit = clr;
		res.tare_scale   = clr;
		res.event_res    = ev;
		case (state_d)
			ST_DISPENSING: res.phase = PHASE_DISPENSING;
			ST_AWAIT_CUP:  res.phase = PHASE_AWAIT_CUP;
			default:       res.phase = PHASE_AWAIT_COIN;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_AWAIT_COIN;
			cup_seen_q     <= 1'b0;
			cup_since_q    <= '0;
			pump_start_q   <= '0;
			start_weight_q <= '0;
			target_q       <= '0;
		end else if (advance) begin
			state_q        <= state_d;
			cup_seen_q     <= cup_seen_d;
			cup_since_q    <= cup_since_d;
			pump_start_q   <= pump_start_d;
			start_weight_q <= start_weight_d;
			target_q       <= target_d;
		end
	end

	// a started tick always leaves the controller dispensing
	a_start_dispensing: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res.event_res == EV_STARTED) |=> state_q == ST_DISPENSING)
		else $error("start event did not enter dispensing");

	// cup seen is dropped whenever the controller leaves for await coin with an event
	a_cup_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ((res.event_res == EV_EARLY) || (res.event_res == EV_TAKEN))
		|=> !cup_seen_q && (state_q == ST_AWAIT_COIN))
		else $error("cup seen not cleared on cup removal");

	// exactly one state bit is set
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

endmodule

// ===== src/cup_dispense_controller_unit.sv =====
// ----------------------------------------------------------------------------
// cup_dispense_controller_unit: tick driven drink dispense controller
// Each tick carries weight, credit and time; each tick yields one result
// with pump drive, credit clear and tare pulses, phase and event code.
// ----------------------------------------------------------------------------
// Usage:
//   Ticks enter on the in channel (in_valid/in_ready) with weight,
//   credit_cents and now_ms. Every tick gives exactly one result on the out
//   channel (out_valid/out_ready), in order.
//   Flow: a tick is registered at its input transfer, evaluated against the
//   controller state when the input register advances and shown on the
//   result register. Throughput: one tick per cycle while results are taken,
//   set by the single state update per tick.
//   When the receiver stalls, the result register holds and one more tick is
//   kept in the input register; in_ready drops once both are full.
//   Reset (arst_n low) returns the controller to await coin with no cup seen,
//   empties both registers and loads the register defaults.
//   Configuration is written over the APB port while no tick is in flight;
//   register i sits at byte address 4*i, pready is always high.
// ----------------------------------------------------------------------------
module cup_dispense_controller_unit #(
	parameter logic [39:0] MinFillTimeMs = cdc_pkg::MinFillMs
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// tick input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            weight,
	input  logic [15:0]                   credit_cents,
	input  logic [39:0]                   now_ms,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pump_on,
	output logic                          clear_credit,
	output logic                          tare_scale,
	output logic [1:0]                    phase,
	output logic [2:0]                    event_res,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdc_pkg::AddrWidth-1:0] paddr,
	input  logic [cdc_pkg::DataWidth-1:0] pwdata,
	output logic [cdc_pkg::DataWidth-1:0] prdata,
	output logic                          pready
);
	import cdc_pkg::*;

	cfg_t               cfg;
	res_t               res;
	logic               valid_s1;
	logic signed [15:0] weight_s1;
	logic [15:0]        credit_s1;
	logic [39:0]        now_s1;
	logic               valid_s2;
	res_t               res_s2;
	logic               advance;
	logic               in_xfer;

	// pipeline flow control
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	// configuration registers
	cdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			weight_s1 <= weight;
			credit_s1 <= credit_cents;
			now_s1    <= now_ms;
		end
	end

	// controller state and tick evaluation
	cdc_step #(
		.MinFillTimeMs (MinFillTimeMs)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.weight       (weight_s1),
		.credit_cents (credit_s1),
		.now_ms       (now_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign pump_on      = res_s2.pump_on;
	assign clear_credit = res_s2.clear_credit;
	assign tare_scale   = res_s2.tare_scale;
	assign phase        = res_s2.phase;
	assign event_res    = res_s2.event_res;

	// pulses appear only with the cup taken event
	a_pulse_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (clear_credit == (event_res == EV_TAKEN)) && (tare_scale == clear_credit))
		else $error("credit clear or tare without cup taken event");

	// pump drive matches the dispensing phase
	a_pump_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pump_on == (phase == PHASE_DISPENSING))
		else $error("pump drive disagrees with phase");

	// a tick taken while the result stalls is held in the input stage
	a_hold_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && valid_s2 && !out_ready |=> valid_s1 && valid_s2)
		else $error("tick lost during output stall");

endmodule

// ===== sim/dispense_result_checker.sv =====
// ----------------------------------------------------------------------------
// dispense_result_checker: result predictor and comparator
// Follows register writes on the configuration port and tick transfers on the
// input channel, works out the result each tick must give, and compares every
// result transfer with the oldest prediction still owed.
// ----------------------------------------------------------------------------
module dispense_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	// tick channel
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [15:0]            weight,
	input  logic [15:0]                   credit_cents,
	input  logic [39:0]                   now_ms,
	// result channel
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          pump_on,
	input  logic                          clear_credit,
	input  logic                          tare_scale,
	input  logic [1:0]                    phase,
	input  logic [2:0]                    event_res,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdc_pkg::AddrWidth-1:0] paddr,
	input  logic [cdc_pkg::DataWidth-1:0] pwdata,
	input  logic                          pready,
	// status toward the testbench top
	output int                            mismatches,
	output int                            owed
);

	import cdc_pkg::*;

	// register copies, kept in step with the configuration port
	cfg_t regs;

	// controller state copy
	logic [1:0]  st_phase;
	logic        cup_present;
	logic [39:0] cup_arrival;
	logic [39:0] fill_start;
	int          fill_base;
	int          fill_target;

	// predicted results not yet seen on the result channel
	res_t awaited_results[$];

	// advance the controller copy by one tick and return the result it gives
	function automatic res_t dispense_outcome(input logic signed [15:0] w_in,
			input logic [15:0] credit, input logic [39:0] now);
		res_t        r;
		int          w, lo, hi, d, vol;
		logic        below, placed, over;
		logic [39:0] el;
		r     = '0;
		w     = int'(w_in);
		lo    = int'(regs.cup_min);
		hi    = int'(regs.cup_max);
		below = w < lo;
		case (st_phase)
			PHASE_DISPENSING: begin
				// added weight in whole ml, truncated toward zero
				d    = w - fill_base;
				vol  = d / 16;
				el   = now - fill_start;
				over = el > {16'd0, regs.timeout};
				if (vol >= fill_target || over) begin
					st_phase    = PHASE_AWAIT_CUP;
					r.event_res = over ? EV_TIMEOUT : EV_FILLED;
				end else if (below && el >= MinFillMs) begin
					cup_present = 1'b0;
					st_phase    = PHASE_AWAIT_COIN;
					r.event_res = EV_EARLY;
				end
			end
			PHASE_AWAIT_CUP: begin
				if (below) begin
					r.clear_credit = 1'b1;
					r.tare_scale   = 1'b1;
					cup_present    = 1'b0;
					st_phase       = PHASE_AWAIT_COIN;
					r.event_res    = EV_TAKEN;
				end
			end
			default: begin
				// cup window tracking and start condition
				placed   = !below && w <= hi;
				st_phase = PHASE_AWAIT_COIN;
				if (placed) begin
					if (!cup_present) begin
						cup_present = 1'b1;
						cup_arrival = now;
					end
				end else begin
					cup_present = 1'b0;
				end
				el = now - cup_arrival;
				if (placed && credit >= regs.small_price && el >= {24'd0, regs.start_delay}) begin
					fill_target = int'((credit >= regs.large_price) ? regs.large_volume
					                                                : regs.small_volume);
					fill_base   = w;
					fill_start  = now;
					st_phase    = PHASE_DISPENSING;
					r.event_res = EV_STARTED;
				end
			end
		endcase
		r.pump_on = (st_phase == PHASE_DISPENSING);
		r.phase   = st_phase;
		return r;
	endfunction

	// register writes, compare on result transfer, predict on tick transfer
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		logic bad;
		if (!arst_n) begin
			regs        = {RstSmallPrice, RstLargePrice, RstSmallVolume, RstLargeVolume,
			               RstCupMin, RstCupMax, RstTimeout, RstStartDelay};
			st_phase    = PHASE_AWAIT_COIN;
			cup_present = 1'b0;
			cup_arrival = '0;
			fill_start  = '0;
			fill_base   = 0;
			fill_target = 0;
			awaited_results.delete();
			mismatches  = 0;
			owed        = 0;
		end else begin
			// configuration write
			if (psel && penable && pwrite && pready) begin
				case (paddr[AddrWidth-1:2])
					REG_SMALL_PRICE:  regs.small_price  = pwdata[15:0];
					REG_LARGE_PRICE:  regs.large_price  = pwdata[15:0];
					REG_SMALL_VOLUME: regs.small_volume = pwdata[9:0];
					REG_LARGE_VOLUME: regs.large_volume = pwdata[9:0];
					REG_CUP_MIN:      regs.cup_min      = pwdata[14:0];
					REG_CUP_MAX:      regs.cup_max      = pwdata[14:0];
					REG_TIMEOUT:      regs.timeout      = pwdata[23:0];
					REG_START_DELAY:  regs.start_delay  = pwdata[15:0];
					default: ;
				endcase
			end

			// result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with no tick owed: %s%b %s%b %s%b %s%0d %s%0d",
							$time, "pump_on=", pump_on, "clear=", clear_credit,
							"tare=", tare_scale, "phase=", phase, "event=", event_res);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					bad  = (pump_on !== want.pump_on) || (clear_credit !== want.clear_credit) ||
					       (tare_scale !== want.tare_scale) || (phase !== want.phase) ||
					       (event_res !== want.event_res);
					if (bad) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch: expected %s%b %s%b %s%b %s%0d %s%0d",
								$time, "pump_on=", want.pump_on, "clear=", want.clear_credit,
								"tare=", want.tare_scale, "phase=", want.phase,
								"event=", want.event_res);
							$display("%0t: result mismatch: got      %s%b %s%b %s%b %s%0d %s%0d",
								$time, "pump_on=", pump_on, "clear=", clear_credit,
								"tare=", tare_scale, "phase=", phase, "event=", event_res);
						end
						mismatches++;
					end
				end
			end

			// tick transfer
			if (in_valid && in_ready)
				awaited_results.push_back(dispense_outcome(weight, credit_cents, now_ms));
			owed = awaited_results.size();
		end
	end

endmodule

// ===== sim/cup_dispense_controller_unit_test.sv =====
// ----------------------------------------------------------------------------
// cup_dispense_controller_unit_test: testbench of the dispense controller
// Drives directed ticks through every phase and event under the reset
// settings, then long runs of dispense sessions mixed with noise ticks under
// several register settings, zero and all-ones among them. Both channels idle
// at random and the receiver once holds off long enough to stall the input.
// Results are predicted and compared by the checker beside the block.
// ----------------------------------------------------------------------------
module cup_dispense_controller_unit_test;

	import cdc_pkg::*;

	localparam int CycleLimit = 200000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [15:0]   weight;
	logic [15:0]          credit_cents;
	logic [39:0]          now_ms;
	logic                 out_valid;
	logic                 out_ready;
	logic                 pump_on;
	logic                 clear_credit;
	logic                 tare_scale;
	logic [1:0]           phase;
	logic [2:0]           event_res;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;

	int          mismatch_total;
	int          results_owed;
	int          ticks_sent = 0;
	int          cycle_count = 0;
	int          recv_cycles = 0;
	logic        held_off = 1'b0;
	logic [39:0] clock_ms;
	cfg_t        active_cfg;

	cup_dispense_controller_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.weight       (weight),
		.credit_cents (credit_cents),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pump_on      (pump_on),
		.clear_credit (clear_credit),
		.tare_scale   (tare_scale),
		.phase        (phase),
		.event_res    (event_res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	dispense_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.weight       (weight),
		.credit_cents (credit_cents),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pump_on      (pump_on),
		.clear_credit (clear_credit),
		.tare_scale   (tare_scale),
		.phase        (phase),
		.event_res    (event_res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatch_total),
		.owed         (results_owed)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("cup_dispense_controller_unit_test: errors");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && !held_off && ticks_sent >= 420) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			recv_cycles++;
			if (recv_cycles >= 2000 && recv_cycles < 2600)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 36);
		end
	end

	// offer one tick at time t and hold it until the transfer
	task automatic tick_at(input int w, input int c, input logic [39:0] t);
		logic took;
		clock_ms = t;
		if (!(ticks_sent >= 900 && ticks_sent < 1150))
			while ($urandom_range(0, 99) < 36) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid     <= 1'b1;
		weight       <= w[15:0];
		credit_cents <= c[15:0];
		now_ms       <= t;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		ticks_sent++;
	endtask

	task automatic tick(input int w, input int c, input int dt);
		tick_at(w, c, clock_ms + 40'(dt));
	endtask

	// wait until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		@(posedge clk);
	endtask

	// setup and access cycle of one register write
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		wait_drained();
		reg_write(REG_SMALL_PRICE, 32'(c.small_price));
		reg_write(REG_LARGE_PRICE, 32'(c.large_price));
		reg_write(REG_SMALL_VOLUME, 32'(c.small_volume));
		reg_write(REG_LARGE_VOLUME, 32'(c.large_volume));
		reg_write(REG_CUP_MIN, 32'(c.cup_min));
		reg_write(REG_CUP_MAX, 32'(c.cup_max));
		reg_write(REG_TIMEOUT, 32'(c.timeout));
		reg_write(REG_START_DELAY, 32'(c.start_delay));
		active_cfg = c;
	endtask

	function automatic cfg_t moderate_cfg();
		cfg_t c;
		c.small_price  = 16'($urandom_range(0, 400));
		c.large_price  = 16'($urandom_range(0, 500));
		c.small_volume = 10'($urandom_range(0, 40));
		c.large_volume = 10'($urandom_range(0, 80));
		c.cup_min      = 15'($urandom_range(0, 300));
		c.cup_max      = 15'(int'(c.cup_min) + int'($urandom_range(0, 600)));
		c.timeout      = 24'($urandom_range(0, 6000));
		c.start_delay  = 16'($urandom_range(0, 3000));
		return c;
	endfunction

	// scale reading below the cup window, mostly close to it
	function automatic int under_window();
		int lo, span;
		lo   = int'(active_cfg.cup_min);
		span = lo + 32767;
		if ($urandom_range(0, 3) != 0 && span > 200)
			span = 200;
		return lo - 1 - int'($urandom_range(0, span));
	endfunction

	// one customer: cup placed, credit, rest, pump, stop or lift, cup taken
	task automatic dispense_session();
		int cw, cred, sp, lp, tgt, full, pre_dt, pump_dt, n, k;
		sp      = int'(active_cfg.small_price);
		lp      = int'(active_cfg.large_price);
		pre_dt  = int'(active_cfg.start_delay) / 3 + 1;
		pump_dt = int'(active_cfg.timeout) / 6 + 1;
		repeat ($urandom_range(0, 2))
			tick(under_window(), $urandom_range(0, 65535), pre_dt);

		// cup weight, often on a window edge
		case ($urandom_range(0, 3))
			0: cw = int'(active_cfg.cup_min);
			1: cw = int'(active_cfg.cup_max);
			default: begin
				cw = int'(active_cfg.cup_min);
				if (active_cfg.cup_max > active_cfg.cup_min)
					cw += $urandom_range(0, active_cfg.cup_max - active_cfg.cup_min);
			end
		endcase

		// credit around the two prices
		case ($urandom_range(0, 4))
			0: cred = $urandom_range(0, 65535);
			1: cred = sp;
			2: cred = lp;
			default: cred = ((sp > lp) ? sp : lp) + $urandom_range(0, 100);
		endcase
		if (cred > 65535)
			cred = 65535;

		// cup rests on the scale, often until the start delay has passed
		n = $urandom_range(3, 6);
		repeat (n)
			tick(cw, cred, $urandom_range(pre_dt / 2, pre_dt + pre_dt / 2));

		tgt  = (cred >= lp) ? int'(active_cfg.large_volume) : int'(active_cfg.small_volume);
		full = cw + tgt * 16;
		if (full > 32767)
			full = 32767;
		case ($urandom_range(0, 3))
			0: begin
				// fill in steps, sometimes touching one sixteenth short of the target
				n = $urandom_range(2, 5);
				for (k = 1; k < n; k++)
					tick(cw + (full - cw) * k / n, cred, $urandom_range(1, pump_dt));
				if ($urandom_range(0, 1))
					tick(full - 1, cred, 1);
				tick(full, cred, 1);
			end
			1: begin
				// supply runs dry
				repeat ($urandom_range(4, 8))
					tick(cw + $urandom_range(0, 15), cred, pump_dt);
			end
			2: begin
				// cup lifted before the shortest fill time, then again around it
				tick(under_window(), cred, $urandom_range(1, 999));
				tick(under_window(), cred, $urandom_range(500, 1500));
			end
			default: tick(full, cred, int'(active_cfg.timeout) + 1);
		endcase

		// cup left on the scale a while, then taken
		repeat ($urandom_range(0, 2))
			tick(full, cred, $urandom_range(1, 2000));
		tick(under_window(), cred, $urandom_range(1, 2000));
	endtask

	// any reading, any credit, time forward or a jump anywhere
	task automatic noise_tick();
		if ($urandom_range(0, 24) == 0)
			tick_at($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535),
				{8'($urandom_range(0, 255)), $urandom});
		else
			tick($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535),
				$urandom_range(0, 3000));
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at  = ticks_sent + count;
		clock_ms = {8'($urandom_range(0, 255)), $urandom};
		while (ticks_sent < stop_at)
			if ($urandom_range(0, 4) == 0)
				noise_tick();
			else
				dispense_session();
	endtask

	// stimulus and verdict
	initial begin
		cfg_t lopsided;
		in_valid     <= 1'b0;
		weight       <= '0;
		credit_cents <= '0;
		now_ms       <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		arst_n       <= 1'b0;
		clock_ms     = '0;
		active_cfg   = {RstSmallPrice, RstLargePrice, RstSmallVolume, RstLargeVolume,
		                RstCupMin, RstCupMax, RstTimeout, RstStartDelay};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reading extremes with no cup
		tick_at(-32768, 0, 40'd0);
		tick_at(32767, 65535, 40'd1);
		// cup on the lower edge, large credit, start exactly at the delay
		tick_at(48, 300, 40'd100);
		tick_at(48, 300, 40'd2099);
		tick_at(48, 300, 40'd2100);
		// one sixteenth short, early lift ignored, then filled
		tick_at(2927, 300, 40'd2600);
		tick_at(47, 300, 40'd2700);
		tick_at(2928, 300, 40'd3000);
		tick_at(100, 300, 40'd3100);
		tick_at(47, 300, 40'd3200);
		// cup on the upper edge, small credit, then abort by lifting
		tick_at(320, 199, 40'd3300);
		tick_at(320, 200, 40'd5300);
		tick_at(-5, 200, 40'd6300);
		// above the window, then timeout limit reached and passed with a full cup
		tick_at(321, 300, 40'd6400);
		tick_at(200, 300, 40'd6500);
		tick_at(200, 300, 40'd8500);
		tick_at(200, 300, 40'd98500);
		tick_at(3080, 300, 40'd98501);
		tick_at(0, 300, 40'd98600);
		// clock going backwards, before and during dispensing
		tick_at(100, 300, 40'd99000);
		tick_at(100, 300, 40'd50000);
		tick_at(100, 300, 40'd50100);
		tick_at(100, 300, 40'd49000);
		tick_at(-1, 300, 40'd49100);

		apply_cfg(moderate_cfg());
		random_phase(250);
		apply_cfg('0);
		random_phase(250);
		apply_cfg(moderate_cfg());
		random_phase(250);
		apply_cfg('1);
		random_phase(250);
		lopsided             = moderate_cfg();
		lopsided.small_price = 16'd500;
		lopsided.large_price = 16'd120;
		apply_cfg(lopsided);
		random_phase(250);
		apply_cfg(moderate_cfg());
		random_phase(250);
		apply_cfg(moderate_cfg());
		random_phase(250);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_total == 0)
			$display("cup_dispense_controller_unit_test: clean");
		else
			$display("cup_dispense_controller_unit_test: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cdc_pkg.sv
src/cdc_regs.sv
src/cdc_step.sv
src/cup_dispense_controller_unit.sv
sim/dispense_result_checker.sv
sim/cup_dispense_controller_unit_test.sv
